### rtl/mirp_pkg.sv
// Shared constants, types and codes for the modulated IR proximity detector.
package mirp_pkg;

    // Window geometry and converter width
    localparam int WINDOW_LEN  = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int SLOT_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW_LEN);

    // Configuration registers
    localparam int REG_W      = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int CMP_W      = (SUM_W > REG_W) ? SUM_W : REG_W;

    localparam logic [REG_W-1:0] FAR_THR_RESET = REG_W'(80);
    localparam logic [REG_W-1:0] SAT_THR_RESET = REG_W'(6960);

    // Ticks before samples start to enter the windows
    localparam int WARMUP_W = 3;
    localparam logic [WARMUP_W-1:0] WARMUP_TICKS = WARMUP_W'(4);

    // Approach ratio: near * NEAR_MUL >= far * FAR_MUL
    localparam int RATIO_W = 3;
    localparam logic [RATIO_W-1:0] NEAR_MUL = RATIO_W'(6);
    localparam logic [RATIO_W-1:0] FAR_MUL  = RATIO_W'(5);

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FAR_THR = 1'b0,
        REG_SAT_THR = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LVL_OFF       = 2'd0,
        LVL_APPROACH  = 2'd1,
        LVL_TRIGGERED = 2'd2,
        LVL_SATURATED = 2'd3
    } level_t;

    // LED sequencer, one step per tick
    typedef enum logic [3:0] {
        PH_NEAR_ON = 4'b0001,
        PH_FAR     = 4'b0010,
        PH_NEAR    = 4'b0100,
        PH_AMBIENT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [SUM_W-1:0] far_sum;
        logic [SUM_W-1:0] near_sum;
        logic [SUM_W-1:0] amb_sum;
    } sums_t;

    typedef struct packed {
        logic [REG_W-1:0] far_thr;
        logic [REG_W-1:0] sat_thr;
    } thresholds_t;

endpackage

### rtl/mirp_window.sv
// Moving-sum window: ring of samples with a running total.
module mirp_window (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [mirp_pkg::SLOT_W-1:0]          slot,
    input  logic [mirp_pkg::SAMPLE_BITS-1:0]     sample,
    output logic [mirp_pkg::SUM_W-1:0]           total
);

    logic [mirp_pkg::SAMPLE_BITS-1:0] entry_reg [mirp_pkg::WINDOW_LEN];
    logic [mirp_pkg::SUM_W-1:0]       total_reg;
    logic [mirp_pkg::SUM_W-1:0]       total_next;

    // Drop the oldest sample, add the new one
    assign total_next = total_reg - mirp_pkg::SUM_W'(entry_reg[slot])
                      + mirp_pkg::SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mirp_pkg::WINDOW_LEN; i++)
            begin
                entry_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (push)
        begin
            entry_reg[slot] <= sample;
            total_reg       <= total_next;
        end
    end

    assign total = total_reg;

endmodule

### rtl/mirp_classify.sv
// Level classifier: saturation check, ambient removal and ratio test.
module mirp_classify (
    input  mirp_pkg::sums_t       sums,
    input  mirp_pkg::thresholds_t thr,
    output mirp_pkg::level_t      level
);

    localparam int PROD_W = mirp_pkg::CMP_W + mirp_pkg::RATIO_W;

    logic [mirp_pkg::CMP_W-1:0] far_raw;
    logic [mirp_pkg::CMP_W-1:0] near_raw;
    logic [mirp_pkg::CMP_W-1:0] amb_raw;
    logic [mirp_pkg::CMP_W-1:0] far_thr;
    logic [mirp_pkg::CMP_W-1:0] sat_thr;
    logic [mirp_pkg::CMP_W-1:0] far_net;
    logic [mirp_pkg::CMP_W-1:0] near_net;
    logic [PROD_W-1:0]          near_scaled;
    logic [PROD_W-1:0]          far_scaled;
    logic                       saturated;
    logic                       far_valid;

    assign far_raw  = mirp_pkg::CMP_W'(sums.far_sum);
    assign near_raw = mirp_pkg::CMP_W'(sums.near_sum);
    assign amb_raw  = mirp_pkg::CMP_W'(sums.amb_sum);
    assign far_thr  = mirp_pkg::CMP_W'(thr.far_thr);
    assign sat_thr  = mirp_pkg::CMP_W'(thr.sat_thr);

    assign saturated = (near_raw >= sat_thr) || (far_raw >= sat_thr);

    // Remove ambient light, clamp at zero
    assign near_net = (near_raw > amb_raw) ? near_raw - amb_raw : '0;
    assign far_net  = (far_raw > amb_raw) ? far_raw - amb_raw : '0;

    assign near_scaled = PROD_W'(near_net) * PROD_W'(mirp_pkg::NEAR_MUL);
    assign far_scaled  = PROD_W'(far_net) * PROD_W'(mirp_pkg::FAR_MUL);
    assign far_valid   = far_net >= far_thr;

    always_comb
    begin
        if (saturated)
            level = mirp_pkg::LVL_SATURATED;
        else if (far_valid && (near_net > far_net))
            level = mirp_pkg::LVL_TRIGGERED;
        else if (far_valid && (near_scaled >= far_scaled))
            level = mirp_pkg::LVL_APPROACH;
        else
            level = mirp_pkg::LVL_OFF;
    end

endmodule

### rtl/modulated_ir_proximity_detector.sv
// Top level of the modulated IR proximity detector: sequencer, windows, result stage.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         tvalid tready tdata[15:0]      one sample tick
//  m_axis    out        tvalid tready tdata[7:0]       LED drives and level
//  cfg       in         cfg_wr_en cfg_addr cfg_wdata   threshold registers
//
// A tick updates the sequencer and the moving sums at the edge it is taken.
// The classified result is then registered into the result stage when that
// stage can take it, and tvalid rises with it.
// One request is taken every cycle while the result side is ready. A stalled
// result lets one more request into the update stage, then holds off input.
// Reset clears all windows and totals at once; no clearing pass follows.
module modulated_ir_proximity_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [SAMPLE_BITS-1:0] adc_sample, rest zero
    input  logic [mirp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] far_led_on, [1] near_led_on, [3:2] level, [7:4] zero
    output logic [mirp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_wr_en,
    input  logic [mirp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mirp_pkg::REG_W-1:0]         cfg_wdata
);

    mirp_pkg::thresholds_t             thr_reg;
    mirp_pkg::phase_t                  phase_reg;
    mirp_pkg::phase_t                  phase_next;
    logic [mirp_pkg::WARMUP_W-1:0]     warmup_reg;
    logic [mirp_pkg::WARMUP_W-1:0]     warmup_next;
    logic                              collecting_reg;
    logic [mirp_pkg::SLOT_W-1:0]       slot_reg;
    logic [mirp_pkg::SLOT_W-1:0]       slot_next;
    logic                              far_led_reg;
    logic                              near_led_reg;
    logic                              far_led_next;
    logic                              near_led_next;
    logic                              push_far;
    logic                              push_near;
    logic                              push_amb;
    logic                              slot_adv;
    logic [mirp_pkg::SAMPLE_BITS-1:0]  sample;
    logic                              in_fire;
    logic                              upd_valid_reg;
    logic                              advance;
    mirp_pkg::sums_t                   sums;
    mirp_pkg::level_t                  level;
    logic                              out_valid_reg;
    logic                              res_far_reg;
    logic                              res_near_reg;
    mirp_pkg::level_t                  res_level_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.far_thr <= mirp_pkg::FAR_THR_RESET;
            thr_reg.sat_thr <= mirp_pkg::SAT_THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (mirp_pkg::cfg_reg_t'(cfg_addr))
                mirp_pkg::REG_FAR_THR: thr_reg.far_thr <= cfg_wdata;
                mirp_pkg::REG_SAT_THR: thr_reg.sat_thr <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: take a request unless the update stage is stuck
    assign advance       = upd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !upd_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sample        = s_axis_tdata[mirp_pkg::SAMPLE_BITS-1:0];

    // LED sequencer and window routing
    always_comb
    begin
        far_led_next  = far_led_reg;
        near_led_next = near_led_reg;
        push_far      = 1'b0;
        push_near     = 1'b0;
        push_amb      = 1'b0;
        slot_adv      = 1'b0;
        phase_next    = phase_reg;
        unique case (phase_reg)
            mirp_pkg::PH_NEAR_ON:
            begin
                far_led_next  = 1'b0;
                near_led_next = 1'b1;
                phase_next    = mirp_pkg::PH_FAR;
            end
            mirp_pkg::PH_FAR:
            begin
                push_far      = collecting_reg;
                near_led_next = 1'b0;
                phase_next    = mirp_pkg::PH_NEAR;
            end
            mirp_pkg::PH_NEAR:
            begin
                push_near  = collecting_reg;
                phase_next = mirp_pkg::PH_AMBIENT;
            end
            mirp_pkg::PH_AMBIENT:
            begin
                push_amb     = collecting_reg;
                slot_adv     = collecting_reg;
                far_led_next = 1'b1;
                phase_next   = mirp_pkg::PH_NEAR_ON;
            end
            default:
            begin
                phase_next = mirp_pkg::PH_NEAR_ON;
            end
        endcase
    end

    assign slot_next   = (slot_reg == mirp_pkg::SLOT_W'(mirp_pkg::WINDOW_LEN - 1))
                       ? '0 : slot_reg + 1'b1;
    assign warmup_next = warmup_reg + 1'b1;

    // Advance sequencer state on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mirp_pkg::PH_NEAR_ON;
            warmup_reg     <= '0;
            collecting_reg <= 1'b0;
            slot_reg       <= '0;
            far_led_reg    <= 1'b0;
            near_led_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            far_led_reg  <= far_led_next;
            near_led_reg <= near_led_next;
            if (slot_adv)
                slot_reg <= slot_next;
            if (!collecting_reg)
            begin
                warmup_reg <= warmup_next;
                if (warmup_next >= mirp_pkg::WARMUP_TICKS)
                    collecting_reg <= 1'b1;
            end
        end
    end

    mirp_window u_far_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_fire && push_far),
        .slot   (slot_reg),
        .sample (sample),
        .total  (sums.far_sum)
    );

    mirp_window u_near_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_fire && push_near),
        .slot   (slot_reg),
        .sample (sample),
        .total  (sums.near_sum)
    );

    mirp_window u_amb_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_fire && push_amb),
        .slot   (slot_reg),
        .sample (sample),
        .total  (sums.amb_sum)
    );

    mirp_classify u_classify (
        .sums  (sums),
        .thr   (thr_reg),
        .level (level)
    );

    // Track an update whose result is not yet registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upd_valid_reg <= 1'b0;
        else if (in_fire)
            upd_valid_reg <= 1'b1;
        else if (advance)
            upd_valid_reg <= 1'b0;
    end

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_far_reg   <= far_led_reg;
            res_near_reg  <= near_led_reg;
            res_level_reg <= level;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_level_reg, res_near_reg, res_far_reg};

endmodule

### rtl/mirp_checker.sv
// Port-level checker for the proximity detector, bound to the top level.
module mirp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [mirp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:4] == 4'b0000))
        else $error("result padding not zero");

    // Never drive both LEDs at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("both LEDs lit");

    // A fresh result follows a request that passed through the update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without request");

endmodule

bind modulated_ir_proximity_detector mirp_checker u_mirp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
